### rtl/asfp_pkg.sv
// Shared types, constants and helpers of the ASCII hex sensor frame parser.
package asfp_pkg;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE   = 8'h0D;
  localparam logic [7:0] TAG_CO2    = 8'h50;
  localparam logic [7:0] TAG_TEMP   = 8'h42;
  localparam logic [7:0] TAG_HUMI   = 8'h41;

  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  localparam int unsigned VAL_W  = 16;
  localparam int unsigned TEMP_W = 20;
  localparam logic signed [TEMP_W-1:0] KELVIN_CENTI = 20'sd27315;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ON  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_OFF = 8'd1;
  localparam logic [VAL_W-1:0] ALARM_ON_RESET  = 16'd2000;
  localparam logic [VAL_W-1:0] ALARM_OFF_RESET = 16'd1200;

  typedef enum logic [1:0] {
    KIND_CO2  = 2'd0,
    KIND_TEMP = 2'd1,
    KIND_HUMI = 2'd2
  } reading_kind_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_RAISED  = 2'd1,
    EV_CLEARED = 2'd2
  } alarm_event_e;

  typedef struct packed {
    logic               valid;
    reading_kind_e      kind;
    logic [VAL_W-1:0]   value;
  } reading_t;

  typedef struct packed {
    logic [VAL_W-1:0]          humidity_raw;
    logic signed [TEMP_W-1:0]  temp_centi_c;
    logic [VAL_W-1:0]          co2_ppm;
    alarm_event_e              alarm_event;
    logic                      alarm_active;
  } report_t;

  // Uppercase ASCII hex digit to its value; anything else decodes as zero.
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

### rtl/asfp_frame.sv
// Frame collector: start byte detection, byte capture and reading decode.
module asfp_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  output asfp_pkg::reading_t  reading_o
);

  logic                       in_frame_q, in_frame_d;
  logic [asfp_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [7:0]                 frame_q [asfp_pkg::FRAME_LEN];
  logic                       last_byte;

  assign last_byte = accept_i && in_frame_q && (idx_q == asfp_pkg::LAST_IDX);

  always_comb begin
    in_frame_d = in_frame_q;
    idx_d      = idx_q;
    if (accept_i) begin
      if (!in_frame_q) begin
        if (rx_byte_i == asfp_pkg::START_BYTE) begin
          in_frame_d = 1'b1;
          idx_d      = '0;
        end
      end else if (idx_q == asfp_pkg::LAST_IDX) begin
        in_frame_d = 1'b0;
        idx_d      = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && in_frame_q) begin
      frame_q[idx_q] <= rx_byte_i;
    end
  end

  always_comb begin
    reading_o.valid = 1'b0;
    reading_o.kind  = asfp_pkg::KIND_CO2;
    reading_o.value = {asfp_pkg::hex_digit(frame_q[1]), asfp_pkg::hex_digit(frame_q[2]),
                       asfp_pkg::hex_digit(frame_q[3]), asfp_pkg::hex_digit(frame_q[4])};
    if (last_byte && rx_byte_i == asfp_pkg::END_BYTE) begin
      priority if (frame_q[0] == asfp_pkg::TAG_CO2) begin
        reading_o.valid = 1'b1;
        reading_o.kind  = asfp_pkg::KIND_CO2;
      end else if (frame_q[0] == asfp_pkg::TAG_TEMP) begin
        reading_o.valid = 1'b1;
        reading_o.kind  = asfp_pkg::KIND_TEMP;
      end else if (frame_q[0] == asfp_pkg::TAG_HUMI) begin
        reading_o.valid = 1'b1;
        reading_o.kind  = asfp_pkg::KIND_HUMI;
      end else begin
        reading_o.valid = 1'b0;
      end
    end
  end

  // A reading can only complete on the eighth byte after the start byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reading_o.valid |-> in_frame_q && idx_q == asfp_pkg::LAST_IDX)
    else $error("reading decoded outside the last frame byte");

endmodule

### rtl/asfp_report.sv
// Report builder: latest readings, seen flags, alarm hysteresis and limits.
module asfp_report (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [asfp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [asfp_pkg::VAL_W-1:0]        cfg_data_i,
  input  asfp_pkg::reading_t                reading_i,
  output logic                              report_valid_o,
  output asfp_pkg::report_t                 report_o
);

  logic [asfp_pkg::VAL_W-1:0] co2_q, temp_q, humi_q;
  logic [asfp_pkg::VAL_W-1:0] co2_d, temp_d, humi_d;
  logic [asfp_pkg::VAL_W-1:0] on_q, off_q;
  logic [2:0]                 seen_q, seen_d, seen_n;
  logic                       alarm_q, alarm_d;
  asfp_pkg::alarm_event_e     event_n;
  logic [20:0]                temp_x25;
  logic [18:0]                temp_quarter;

  always_comb begin
    co2_d  = co2_q;
    temp_d = temp_q;
    humi_d = humi_q;
    seen_n = seen_q;
    if (reading_i.valid) begin
      unique case (reading_i.kind)
        asfp_pkg::KIND_CO2: begin
          co2_d     = reading_i.value;
          seen_n[0] = 1'b1;
        end
        asfp_pkg::KIND_TEMP: begin
          temp_d    = reading_i.value;
          seen_n[1] = 1'b1;
        end
        asfp_pkg::KIND_HUMI: begin
          humi_d    = reading_i.value;
          seen_n[2] = 1'b1;
        end
        default: begin
          seen_n = seen_q;
        end
      endcase
    end
  end

  assign report_valid_o = reading_i.valid && (&seen_n);

  always_comb begin
    alarm_d = alarm_q;
    event_n = asfp_pkg::EV_NONE;
    if (!alarm_q && co2_d >= on_q) begin
      event_n = asfp_pkg::EV_RAISED;
      alarm_d = 1'b1;
    end else if (alarm_q && co2_d < off_q) begin
      event_n = asfp_pkg::EV_CLEARED;
      alarm_d = 1'b0;
    end
  end

  always_comb begin
    seen_d = seen_n;
    if (report_valid_o) begin
      seen_d = '0;
    end
  end

  // Multiply by 25 as shifts and adds, then divide by four.
  assign temp_x25     = {1'b0, temp_d, 4'b0} + {2'b0, temp_d, 3'b0} + {5'b0, temp_d};
  assign temp_quarter = temp_x25[20:2];

  always_comb begin
    report_o.humidity_raw = humi_d;
    report_o.temp_centi_c = $signed({1'b0, temp_quarter}) - asfp_pkg::KELVIN_CENTI;
    report_o.co2_ppm      = co2_d;
    report_o.alarm_event  = event_n;
    report_o.alarm_active = alarm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      co2_q   <= '0;
      temp_q  <= '0;
      humi_q  <= '0;
      seen_q  <= '0;
      alarm_q <= 1'b0;
      on_q    <= asfp_pkg::ALARM_ON_RESET;
      off_q   <= asfp_pkg::ALARM_OFF_RESET;
    end else begin
      co2_q  <= co2_d;
      temp_q <= temp_d;
      humi_q <= humi_d;
      seen_q <= seen_d;
      if (report_valid_o) begin
        alarm_q <= alarm_d;
      end
      if (cfg_valid_i && cfg_index_i == asfp_pkg::CFG_ALARM_ON) begin
        on_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == asfp_pkg::CFG_ALARM_OFF) begin
        off_q <= cfg_data_i;
      end
    end
  end

  // The alarm state only moves when a report goes out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !report_valid_o |=> $stable(alarm_q))
    else $error("alarm state changed without a report");

  // The registered seen flags are never all set at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != 3'b111)
    else $error("seen flags left fully set");

endmodule

### rtl/asfp_out_buf.sv
// Output register with one skid entry for the report channel.
module asfp_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  asfp_pkg::report_t  push_data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output asfp_pkg::report_t  out_data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  asfp_pkg::report_t out_q, out_d, skid_q, skid_d;
  logic              out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while the output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("report pushed while the skid entry is occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && out_q == $past(out_q))
    else $error("stalled report was lost or changed");

endmodule

### rtl/ascii_hex_sensor_frame_parser.sv
// A report is built from its completing byte and registered in the output buffer.
// Throughput: one byte per cycle; the byte channel stalls only while a second
// report waits in the skid entry behind a stalled output register.
// Reset: asynchronous, active low; clears the frame state, readings, seen flags
// and alarm state, and loads the alarm limits with 2000 and 1200.
module ascii_hex_sensor_frame_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [asfp_pkg::VAL_W-1:0]        humidity_raw_o,
  output logic signed [asfp_pkg::TEMP_W-1:0] temp_centi_c_o,
  output logic [asfp_pkg::VAL_W-1:0]        co2_ppm_o,
  output logic [1:0]                        alarm_event_o,
  output logic                              alarm_active_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [asfp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [asfp_pkg::VAL_W-1:0]        cfg_data_i
);

  logic               accept;
  logic               buf_full;
  logic               report_valid;
  asfp_pkg::reading_t reading;
  asfp_pkg::report_t  report;
  asfp_pkg::report_t  out_data;

  assign in_stall_o  = buf_full;
  assign accept      = in_valid_i && !buf_full;
  assign cfg_ready_o = 1'b1;

  asfp_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .reading_o (reading)
  );

  asfp_report u_report (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .reading_i      (reading),
    .report_valid_o (report_valid),
    .report_o       (report)
  );

  asfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (report_valid),
    .push_data_i (report),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign humidity_raw_o = out_data.humidity_raw;
  assign temp_centi_c_o = out_data.temp_centi_c;
  assign co2_ppm_o      = out_data.co2_ppm;
  assign alarm_event_o  = out_data.alarm_event;
  assign alarm_active_o = out_data.alarm_active;

endmodule

### bench/tb_ascii_hex_sensor_frame_parser.sv
// Self-checking testbench for the ASCII hex sensor frame parser with a built-in report predictor.
module tb_ascii_hex_sensor_frame_parser;
  import asfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 240;
  localparam int unsigned PHASE_REPORTS = 6;

  typedef struct packed {
    logic [71:0] seq;
    logic [3:0]  count;
    logic        typed;
    report_t     want;
  } step_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [7:0]               rx_byte_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [VAL_W-1:0]         humidity_raw_o;
  logic signed [TEMP_W-1:0] temp_centi_c_o;
  logic [VAL_W-1:0]         co2_ppm_o;
  logic [1:0]               alarm_event_o;
  logic                     alarm_active_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [VAL_W-1:0]         cfg_data_i;

  // Predictor state and alarm limits.
  logic             in_frame_m;
  logic [IDX_W-1:0] slot_m;
  logic [7:0]       frame_m [FRAME_LEN];
  logic [15:0]      co2_m;
  logic [15:0]      temp_m;
  logic [15:0]      humi_m;
  logic [2:0]       seen_m;
  logic             alarm_m;
  logic [15:0]      on_lvl;
  logic [15:0]      off_lvl;

  report_t       pending_reports [$];
  report_t       fresh;
  report_t       oldest;
  report_t       directed_want;
  logic          directed_want_on;
  logic          quiet;
  reading_kind_e next_kind;
  step_row_t     directed_steps [13];
  int unsigned   bytes_sent;
  int unsigned   reports_predicted;
  int unsigned   results_checked;
  int unsigned   mismatches;
  int unsigned   cycle_count;

  ascii_hex_sensor_frame_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .humidity_raw_o (humidity_raw_o),
    .temp_centi_c_o (temp_centi_c_o),
    .co2_ppm_o      (co2_ppm_o),
    .alarm_event_o  (alarm_event_o),
    .alarm_active_o (alarm_active_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end
    return d[3:0];
  endfunction

  function automatic logic [31:0] hex_text(input logic [15:0] v);
    logic [3:0] nib;
    hex_text = '0;
    for (int i = 0; i < 4; i++) begin
      nib = v[4*i +: 4];
      hex_text[8*i +: 8] = (nib < 4'd10) ? 8'h30 + nib : 8'h37 + nib;
    end
  endfunction

  // Advances the predicted parser by one byte; returns 1 when a report is due.
  function automatic logic absorb_byte(input logic [7:0] b, output report_t rep);
    logic [15:0] val;
    int t;
    rep = '0;
    if (!in_frame_m) begin
      if (b == START_BYTE) begin
        in_frame_m = 1'b1;
        slot_m = '0;
      end
      return 1'b0;
    end
    frame_m[slot_m] = b;
    if (slot_m != LAST_IDX) begin
      slot_m = slot_m + 1'b1;
      return 1'b0;
    end
    in_frame_m = 1'b0;
    slot_m = '0;
    val = {digit_value(frame_m[1]), digit_value(frame_m[2]),
           digit_value(frame_m[3]), digit_value(frame_m[4])};
    if (frame_m[7] == END_BYTE) begin
      case (frame_m[0])
        TAG_CO2: begin
          co2_m = val;
          seen_m[KIND_CO2] = 1'b1;
        end
        TAG_TEMP: begin
          temp_m = val;
          seen_m[KIND_TEMP] = 1'b1;
        end
        TAG_HUMI: begin
          humi_m = val;
          seen_m[KIND_HUMI] = 1'b1;
        end
        default: ;
      endcase
    end
    if (!(&seen_m)) begin
      return 1'b0;
    end
    seen_m = '0;
    rep.alarm_event = EV_NONE;
    if (!alarm_m && co2_m >= on_lvl) begin
      alarm_m = 1'b1;
      rep.alarm_event = EV_RAISED;
    end else if (alarm_m && co2_m < off_lvl) begin
      alarm_m = 1'b0;
      rep.alarm_event = EV_CLEARED;
    end
    t = ((int'(temp_m) * 25) >>> 2) - 27315;
    rep.humidity_raw = humi_m;
    rep.temp_centi_c = t[19:0];
    rep.co2_ppm = co2_m;
    rep.alarm_active = alarm_m;
    return 1'b1;
  endfunction

  function automatic step_row_t frame_row(input logic [7:0] tag, input logic [31:0] digits,
                                          input logic [15:0] pad, input logic [7:0] tail,
                                          input logic typed, input report_t want);
    frame_row.seq = {START_BYTE, tag, digits, pad, tail};
    frame_row.count = 4'd9;
    frame_row.typed = typed;
    frame_row.want = want;
  endfunction

  task automatic flag_field(input string what, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Output checking, then prediction of the byte transaction, then register writes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (pending_reports.size() == 0) begin
          $display("%0t: report with none expected, expected nothing, got co2 %0d",
                   $time, co2_ppm_o);
          mismatches++;
        end else begin
          oldest = pending_reports.pop_front();
          if (humidity_raw_o !== oldest.humidity_raw)
            flag_field("humidity_raw", oldest.humidity_raw, humidity_raw_o);
          if (temp_centi_c_o !== oldest.temp_centi_c)
            flag_field("temp_centi_c", int'(oldest.temp_centi_c), int'(temp_centi_c_o));
          if (co2_ppm_o !== oldest.co2_ppm)
            flag_field("co2_ppm", oldest.co2_ppm, co2_ppm_o);
          if (alarm_event_o !== oldest.alarm_event)
            flag_field("alarm_event", oldest.alarm_event, alarm_event_o);
          if (alarm_active_o !== oldest.alarm_active)
            flag_field("alarm_active", oldest.alarm_active, alarm_active_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (absorb_byte(rx_byte_i, fresh)) begin
          pending_reports.push_back(directed_want_on ? directed_want : fresh);
          reports_predicted++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ALARM_ON: on_lvl = cfg_data_i;
          CFG_ALARM_OFF: off_lvl = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Result receiver: random stalls, one long hold-off, and none while quiet.
  initial begin
    logic held;
    held = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_checked >= 6) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 29);
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic typed, input report_t want);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    directed_want_on = typed;
    directed_want = want;
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [71:0] seq, input int count, input logic typed,
                          input report_t want);
    for (int i = 0; i < count; i++) begin
      offer_byte(seq[71-8*i -: 8], typed, want);
    end
  endtask

  task automatic drop_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random_unit();
    reading_kind_e kind;
    logic [7:0] tag;
    logic [15:0] v;
    logic [31:0] txt;
    int r;
    r = $urandom_range(99);
    if (r < 80) begin
      if ($urandom_range(99) < 70) begin
        kind = next_kind;
      end else begin
        kind = reading_kind_e'($urandom_range(2));
      end
      next_kind = (kind == KIND_HUMI) ? KIND_CO2 : reading_kind_e'(kind + 1);
      v = ($urandom_range(9) == 0) ? {16{$urandom_range(1) == 1}} : 16'($urandom);
      case (kind)
        KIND_CO2: begin
          tag = TAG_CO2;
          case ($urandom_range(3))
            0: v = on_lvl + 16'($urandom_range(6)) - 16'd3;
            1: v = off_lvl + 16'($urandom_range(6)) - 16'd3;
            default: ;
          endcase
        end
        KIND_TEMP: tag = TAG_TEMP;
        default: tag = TAG_HUMI;
      endcase
      txt = hex_text(v);
      if ($urandom_range(9) == 0) begin
        txt[8*$urandom_range(3) +: 8] = 8'($urandom);
      end
      send_seq({START_BYTE, tag, txt, 16'($urandom), END_BYTE}, 9, 1'b0, '0);
    end else if (r < 90) begin
      repeat ($urandom_range(4, 1)) offer_byte(8'($urandom), 1'b0, '0);
    end else begin
      send_seq({START_BYTE, 8'($urandom), 32'($urandom), 16'($urandom),
                ($urandom_range(1) == 1) ? END_BYTE : 8'($urandom)}, 9, 1'b0, '0);
    end
  endtask

  initial begin
    logic [15:0] on_next;
    logic [15:0] off_next;
    int unsigned first_byte;
    int unsigned first_report;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i = 8'h00;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    quiet = 1'b0;
    directed_want_on = 1'b0;
    directed_want = '0;
    next_kind = KIND_CO2;
    in_frame_m = 1'b0;
    slot_m = '0;
    co2_m = '0;
    temp_m = '0;
    humi_m = '0;
    seen_m = '0;
    alarm_m = 1'b0;
    on_lvl = ALARM_ON_RESET;
    off_lvl = ALARM_OFF_RESET;
    bytes_sent = 0;
    reports_predicted = 0;
    results_checked = 0;
    mismatches = 0;
    cycle_count = 0;
    directed_steps = '{
      '{seq: {8'h00, 8'hFF, END_BYTE, TAG_CO2, 8'h80, 32'h0}, count: 4'd5, typed: 1'b0,
        want: '0},
      frame_row(TAG_CO2, "FFFF", 16'hFF00, END_BYTE, 1'b0, '0),
      frame_row(TAG_TEMP, "0000", {START_BYTE, START_BYTE}, END_BYTE, 1'b0, '0),
      frame_row(TAG_HUMI, "FFFF", 16'h00FF, END_BYTE, 1'b1,
                '{16'hFFFF, -20'sd27315, 16'hFFFF, EV_RAISED, 1'b1}),
      frame_row(TAG_CO2, "0000", {END_BYTE, END_BYTE}, 8'h0C, 1'b0, '0),
      frame_row(8'h43, "1234", {END_BYTE, END_BYTE}, END_BYTE, 1'b0, '0),
      frame_row(TAG_CO2, "@:/G", 16'h3041, END_BYTE, 1'b0, '0),
      frame_row(TAG_CO2, "a001", 16'h4600, END_BYTE, 1'b0, '0),
      frame_row(TAG_TEMP, "FFFF", 16'h5555, END_BYTE, 1'b0, '0),
      frame_row(TAG_HUMI, "0000", 16'hAAAA, END_BYTE, 1'b1,
                '{16'h0000, 20'sd382278, 16'h0001, EV_CLEARED, 1'b0}),
      frame_row(TAG_CO2, "07D0", 16'h0000, END_BYTE, 1'b0, '0),
      frame_row(TAG_HUMI, "9ABC", 16'h0F0F, END_BYTE, 1'b0, '0),
      frame_row(TAG_TEMP, "8E5F", 16'hF0F0, END_BYTE, 1'b0, '0)
    };
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i]) begin
      send_seq(directed_steps[i].seq, directed_steps[i].count, directed_steps[i].typed,
               directed_steps[i].want);
    end

    for (int phase = 0; phase < 7; phase++) begin
      if (phase > 0) begin
        drop_input();
        while (pending_reports.size() != 0) @(negedge clk_i);
        repeat (4) @(negedge clk_i);
        case (phase)
          1: begin on_next = 16'h0000; off_next = 16'h0000; end
          2: begin on_next = 16'hFFFF; off_next = 16'hFFFF; end
          3: begin on_next = 16'h0000; off_next = 16'hFFFF; end
          4: begin on_next = 16'hFFFF; off_next = 16'h0000; end
          5: begin on_next = 16'd1000; off_next = 16'd3000; end
          default: begin on_next = 16'($urandom); off_next = 16'($urandom); end
        endcase
        write_reg(CFG_ALARM_ON, on_next);
        write_reg(CFG_ALARM_OFF, off_next);
        write_reg(CFG_IDX_W'($urandom_range(255, 2)), 16'($urandom));
        @(negedge clk_i);
        cfg_valid_i <= 1'b0;
      end
      quiet = (phase == 2);
      first_byte = bytes_sent;
      first_report = reports_predicted;
      while (bytes_sent - first_byte < PHASE_BYTES ||
             reports_predicted - first_report < PHASE_REPORTS) begin
        send_random_unit();
      end
    end

    drop_input();
    quiet = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
